// ===== rtl/gbc_pkg.sv =====
// Shared types, constants and helpers for the gyro bias compensation filter.
`default_nettype none
package gbc_pkg;

  // Field widths
  localparam int AXES    = 3;
  localparam int BYTE_W  = 8;
  localparam int RAW_W   = 17;  // signed 16-bit axis plus room for negation
  localparam int RATE_W  = 25;  // saturated rate, bias and filter width
  localparam int WIDE_W  = 27;  // intermediate width ahead of saturation
  localparam int THR_W   = 23;
  localparam int SETTLE_W = 16;
  localparam int GAIN_W  = 16;

  // Configuration port
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  // Default parameter values
  localparam int CALIB_SAMPLES_DEF = 100;
  localparam int FRAC_BITS_DEF     = 8;

  // Register reset values
  localparam logic [THR_W-1:0]    THRESHOLD_RST = 23'd12583;
  localparam logic [SETTLE_W-1:0] SETTLE_RST    = 16'd4000;
  localparam logic [GAIN_W-1:0]   GAIN_RST      = 16'd10294;
  localparam logic [GAIN_W-1:0]   LPF_RST       = 16'd32768;

  // Register map, word index
  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_SETTLE    = 2'd1,
    REG_GAIN      = 2'd2,
    REG_LPF       = 2'd3
  } reg_idx_t;

  typedef logic signed [RATE_W-1:0] rate_t;
  typedef logic signed [RAW_W-1:0]  raw_t;

  // Control from the top level to every lane
  typedef struct packed {
    logic accept;       // word taken this cycle
    logic calib;        // calibration word
    logic calib_first;  // calibration word that opens a new average
    logic comp;         // compensation active before this word
    logic adapt;        // drift bias moves this word
    logic calib_end;    // count would close the average on a calibration word
    logic filt_update;  // filter advances on a non-calibration word leaving stage 1
  } gbc_ctl_t;

  // Status from a lane
  typedef struct packed {
    logic in_range;
    logic div_busy;
  } gbc_sts_t;

  localparam logic signed [WIDE_W-1:0] WIDE_RATE_MAX = WIDE_W'((1 <<< (RATE_W-1)) - 1);
  localparam logic signed [WIDE_W-1:0] WIDE_RATE_MIN = -WIDE_RATE_MAX - WIDE_W'(1);

  // Clamp to the signed rate range
  function automatic rate_t sat_rate(input logic signed [WIDE_W-1:0] v);
    rate_t r;
    if (v > WIDE_RATE_MAX) begin
      r = WIDE_RATE_MAX[RATE_W-1:0];
    end else if (v < WIDE_RATE_MIN) begin
      r = WIDE_RATE_MIN[RATE_W-1:0];
    end else begin
      r = v[RATE_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/gyro_bias_compensation_filter_unit.sv =====
// Top level: stream ports, register file, stationary merge and output stage.
//
// Takes one three-axis gyro word per cycle while s_tready is high (six raw bytes,
// calibration flag in s_tuser) and returns corrected and low-pass filtered rates in
// sensor LSB with FRAC_BITS fraction bits, through the stage 1 register and then the
// output register. Three axis lanes run side by side; their in-range flags merge into
// one stationary decision that steers the drift bias, and that drift update (one 25x17
// multiply) is combinational, so words may follow back to back. The calibration word
// that completes an average of CALIB_SAMPLES words starts a per-lane reciprocal
// multiply and the input is held off while the new static bias forms; no other word
// starts it. Registers sit at byte addresses 0x0 threshold, 0x4 settle count, 0x8
// drift gain, 0xC filter ratio; the user must write them only while the block is
// idle, and the block itself does not enforce this.
`default_nettype none
module gyro_bias_compensation_filter_unit #(
  parameter int CALIB_SAMPLES = gbc_pkg::CALIB_SAMPLES_DEF,
  parameter int FRAC_BITS     = gbc_pkg::FRAC_BITS_DEF
) (
  input  wire         clk,
  input  wire         rst,
  // x_low, x_high, y_low, y_high, z_low, z_high
  input  wire  [47:0] s_tdata,
  // kind
  input  wire  [0:0]  s_tuser,
  input  wire         s_tvalid,
  output logic        s_tready,
  // rate_a, rate_b, rate_c, smooth_a, smooth_b, smooth_c, zero pad
  output logic [151:0] m_tdata,
  // compensating
  output logic [0:0]  m_tuser,
  output logic        m_tvalid,
  input  wire         m_tready,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [gbc_pkg::APB_ADDR_W-1:0] paddr,
  input  wire  [gbc_pkg::APB_DATA_W-1:0] pwdata,
  output logic [gbc_pkg::APB_DATA_W-1:0] prdata,
  output logic        pready
);
  import gbc_pkg::*;

  localparam int CNT_W = $clog2(CALIB_SAMPLES + 1);

  // Configuration registers
  logic [THR_W-1:0]    rate_threshold;
  logic [SETTLE_W-1:0] settle_samples;
  logic [GAIN_W-1:0]   bias_gain;
  logic [GAIN_W-1:0]   lpf_ratio;

  // Block state
  logic [CNT_W-1:0]    calib_count;
  logic [SETTLE_W-1:0] still_count;
  logic                comp_enabled;

  // Pipeline control
  logic s1_valid;
  logic s1_calib;
  logic s1_comp;
  logic accept;
  logic out_load;
  logic div_busy;

  logic [15:0]         axis_x;
  logic [15:0]         axis_y;
  logic [15:0]         axis_z;
  raw_t                lane_raw [AXES];
  rate_t               lane_rate [AXES];
  rate_t               lane_smooth [AXES];
  gbc_sts_t            lane_sts [AXES];
  gbc_ctl_t            ctl;
  logic                still;
  logic [SETTLE_W-1:0] still_inc;
  logic [CNT_W:0]      cnt_inc;
  logic                calib_end;
  reg_idx_t            reg_idx;
  logic                cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign cfg_write = psel & penable & pwrite & pready;

  // Register read
  always_comb begin
    case (reg_idx)
      REG_THRESHOLD: prdata = APB_DATA_W'(rate_threshold);
      REG_SETTLE:    prdata = APB_DATA_W'(settle_samples);
      REG_GAIN:      prdata = APB_DATA_W'(bias_gain);
      REG_LPF:       prdata = APB_DATA_W'(lpf_ratio);
      default:       prdata = '0;
    endcase
  end

  // Register write
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_threshold <= THRESHOLD_RST;
      settle_samples <= SETTLE_RST;
      bias_gain      <= GAIN_RST;
      lpf_ratio      <= LPF_RST;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_THRESHOLD: rate_threshold <= pwdata[THR_W-1:0];
        REG_SETTLE:    settle_samples <= pwdata[SETTLE_W-1:0];
        REG_GAIN:      bias_gain      <= pwdata[GAIN_W-1:0];
        REG_LPF:       lpf_ratio      <= pwdata[GAIN_W-1:0];
        default:       ;
      endcase
    end
  end

  // Axis assembly: axis 0 = y, axis 1 = x, axis 2 = -z
  always_comb begin
    axis_x      = s_tdata[15:0];
    axis_y      = s_tdata[31:16];
    axis_z      = s_tdata[47:32];
    lane_raw[0] = RAW_W'($signed(axis_y));
    lane_raw[1] = RAW_W'($signed(axis_x));
    lane_raw[2] = -RAW_W'($signed(axis_z));
  end

  // Handshake
  assign div_busy = lane_sts[0].div_busy | lane_sts[1].div_busy | lane_sts[2].div_busy;
  assign out_load = s1_valid & (~m_tvalid | m_tready);
  assign s_tready = ~div_busy & (~s1_valid | ~m_tvalid | m_tready);
  assign accept   = s_tvalid & s_tready;

  // Merge of lane flags and word-level decisions
  always_comb begin
    still     = lane_sts[0].in_range & lane_sts[1].in_range & lane_sts[2].in_range;
    still_inc = (still_count == '1) ? still_count : still_count + SETTLE_W'(1);
    cnt_inc   = (CNT_W+1)'(calib_count) + (CNT_W+1)'(1);
    calib_end = cnt_inc >= (CNT_W+1)'(CALIB_SAMPLES);

    ctl.accept      = accept;
    ctl.calib       = s_tuser[0];
    ctl.calib_first = s_tuser[0] & (calib_count == '0);
    ctl.comp        = comp_enabled;
    ctl.adapt       = comp_enabled & still & (still_inc > settle_samples);
    ctl.calib_end   = calib_end;
    ctl.filt_update = out_load & ~s1_calib;
  end

  for (genvar i = 0; i < AXES; i++) begin : g_lane
    gbc_lane #(
      .FRAC_BITS     (FRAC_BITS),
      .CALIB_SAMPLES (CALIB_SAMPLES)
    ) u_lane (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .raw         (lane_raw[i]),
      .thr         (rate_threshold),
      .gain        (bias_gain),
      .lpf_ratio   (lpf_ratio),
      .rate_s1     (lane_rate[i]),
      .smooth_next (lane_smooth[i]),
      .sts         (lane_sts[i])
    );
  end

  // Word-level state
  always_ff @(posedge clk) begin
    if (rst) begin
      calib_count  <= '0;
      still_count  <= '0;
      comp_enabled <= 1'b0;
    end else if (accept) begin
      if (comp_enabled) begin
        still_count <= still ? still_inc : '0;
      end
      if (s_tuser[0]) begin
        if (calib_end) begin
          calib_count  <= '0;
          comp_enabled <= 1'b1;
        end else begin
          calib_count <= cnt_inc[CNT_W-1:0];
        end
      end
    end
  end

  // Stage 1 and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (out_load) begin
        s1_valid <= 1'b0;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Stage 1 flags and output word
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_calib <= s_tuser[0];
      s1_comp  <= comp_enabled | (s_tuser[0] & calib_end);
    end
    if (out_load) begin
      m_tdata <= {2'b00, lane_smooth[2], lane_smooth[1], lane_smooth[0],
                  lane_rate[2], lane_rate[1], lane_rate[0]};
      m_tuser <= s1_comp;
    end
  end

  // Closing a calibration average must hold off the next word
  a_div_holds_input: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser[0] && calib_end) |=> !s_tready)
    else $error("input taken while static bias is being computed");

  // Compensation never turns off outside reset
  a_comp_sticky: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> !$fell(comp_enabled))
    else $error("compensation dropped without reset");

  // An out-of-range word under compensation clears the still counter
  a_still_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && comp_enabled && !still) |=> (still_count == '0))
    else $error("still counter not cleared on motion");

endmodule
`default_nettype wire

// ===== rtl/gbc_div.sv =====
// Division by a fixed count through reciprocal multiplication, truncating toward zero.
`default_nettype none
module gbc_div #(
  parameter int SUM_W   = 32,
  parameter int DIVISOR = 100
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      start,
  input  wire logic signed [SUM_W-1:0] dividend,
  output logic                     busy,
  output logic                     done,
  output gbc_pkg::rate_t           quotient
);
  import gbc_pkg::*;

  // floor(m / DIVISOR) == (m * RECIP) >> SHIFT for every magnitude below 2^(SUM_W-1)
  localparam int SHIFT  = SUM_W - 1 + $clog2(DIVISOR);
  localparam int PROD_W = 2 * SUM_W;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [SUM_W-1:0] RECIP = RECIP_FULL[SUM_W-1:0];

  logic                    running;
  logic signed [SUM_W-1:0] num;
  logic                    neg;
  logic [SUM_W-1:0]        mag;
  logic [PROD_W-1:0]       prod;
  logic [SUM_W-1:0]        q_mag;
  logic [SUM_W-1:0]        q_signed;

  // Magnitude times reciprocal, sign restored on the way out
  always_comb begin
    mag      = num[SUM_W-1] ? SUM_W'(-num) : SUM_W'(num);
    prod     = PROD_W'(mag) * PROD_W'(RECIP);
    q_signed = neg ? SUM_W'(-q_mag) : q_mag;
  end

  // Average never leaves the rate range, so the low bits are the result
  assign quotient = q_signed[RATE_W-1:0];
  assign busy     = running | done;

  // Sequencing: capture, multiply, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      running <= start;
      done    <= running;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
    end
    if (running) begin
      neg   <= num[SUM_W-1];
      q_mag <= SUM_W'(prod >> SHIFT);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/gbc_lane.sv =====
// One axis: bias removal, drift tracking, calibration sum and low-pass filter.
`default_nettype none
module gbc_lane #(
  parameter int FRAC_BITS     = 8,
  parameter int CALIB_SAMPLES = 100
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire gbc_pkg::gbc_ctl_t       ctl,
  input  wire gbc_pkg::raw_t           raw,
  input  wire logic [gbc_pkg::THR_W-1:0]  thr,
  input  wire logic [gbc_pkg::GAIN_W-1:0] gain,
  input  wire logic [gbc_pkg::GAIN_W-1:0] lpf_ratio,
  output gbc_pkg::rate_t               rate_s1,
  output gbc_pkg::rate_t               smooth_next,
  output gbc_pkg::gbc_sts_t            sts
);
  import gbc_pkg::*;

  localparam int SCL_W  = RAW_W + FRAC_BITS;
  localparam int DIFF_W = (SCL_W > RATE_W ? SCL_W : RATE_W) + 1;
  localparam int CNT_W  = $clog2(CALIB_SAMPLES + 1);
  localparam int SUM_W  = RATE_W + CNT_W;
  localparam int DP_W   = RATE_W + GAIN_W + 1;
  localparam int FP_W   = RATE_W + GAIN_W + 2;

  localparam logic signed [DIFF_W-1:0] D_MAX = DIFF_W'((1 <<< (RATE_W-1)) - 1);
  localparam logic signed [DIFF_W-1:0] D_MIN = -D_MAX - DIFF_W'(1);
  localparam logic signed [FP_W-1:0]   ROUND = FP_W'(1 <<< (GAIN_W-1));

  rate_t static_bias;
  rate_t drift_bias;
  rate_t smoothed_rate;
  logic signed [SUM_W-1:0] calib_sum;

  rate_t                    sb_eff;
  logic signed [DIFF_W-1:0] scaled;
  logic signed [DIFF_W-1:0] diff0;
  rate_t                    r0;
  rate_t                    r1;
  rate_t                    rate;
  logic signed [RATE_W:0]   rate_wide;
  logic [RATE_W-1:0]        mag;
  logic signed [DP_W-1:0]   dprod;
  logic signed [WIDE_W-1:0] dstep;
  rate_t                    drift_next;
  logic signed [SUM_W-1:0]  sum_base;
  logic signed [SUM_W-1:0]  sum_next;
  logic signed [RATE_W:0]   fdiff;
  logic signed [FP_W-1:0]   fprod;
  logic signed [WIDE_W-1:0] fstep;
  rate_t                    smooth_calc;
  logic                     div_start;
  logic                     div_busy;
  logic                     div_done;
  rate_t                    div_q;

  // Scale, static bias, then drift bias
  always_comb begin
    sb_eff = ctl.calib_first ? '0 : static_bias;
    scaled = DIFF_W'(raw) <<< FRAC_BITS;
    diff0  = scaled - DIFF_W'(sb_eff);
    if (diff0 > D_MAX) begin
      r0 = D_MAX[RATE_W-1:0];
    end else if (diff0 < D_MIN) begin
      r0 = D_MIN[RATE_W-1:0];
    end else begin
      r0 = diff0[RATE_W-1:0];
    end
    r1   = sat_rate(WIDE_W'(r0) - WIDE_W'(drift_bias));
    rate = ctl.comp ? r1 : r0;
  end

  // Stationary test on this axis
  always_comb begin
    rate_wide = (RATE_W+1)'(rate);
    mag       = rate[RATE_W-1] ? RATE_W'(-rate_wide) : RATE_W'(rate_wide);
  end

  // Drift step: floor(rate * gain / 2^16)
  always_comb begin
    dprod      = rate * $signed({1'b0, gain});
    dstep      = WIDE_W'(dprod >>> GAIN_W);
    drift_next = sat_rate(WIDE_W'(drift_bias) + dstep);
  end

  // Calibration running sum
  always_comb begin
    sum_base = ctl.calib_first ? '0 : calib_sum;
    sum_next = sum_base + SUM_W'(rate);
  end

  // Filter: old + round((new - old) * ratio / 2^16)
  always_comb begin
    fdiff       = (RATE_W+1)'(rate_s1) - (RATE_W+1)'(smoothed_rate);
    fprod       = fdiff * $signed({1'b0, lpf_ratio});
    fstep       = WIDE_W'((fprod + ROUND) >>> GAIN_W);
    smooth_calc = sat_rate(WIDE_W'(smoothed_rate) + fstep);
    smooth_next = ctl.filt_update ? smooth_calc : smoothed_rate;
  end

  assign div_start = ctl.accept & ctl.calib & ctl.calib_end;

  gbc_div #(
    .SUM_W   (SUM_W),
    .DIVISOR (CALIB_SAMPLES)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_next),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  assign sts.in_range = mag < RATE_W'(thr);
  assign sts.div_busy = div_busy;

  // Axis state
  always_ff @(posedge clk) begin
    if (rst) begin
      static_bias   <= '0;
      drift_bias    <= '0;
      smoothed_rate <= '0;
      calib_sum     <= '0;
    end else begin
      if (ctl.accept && ctl.adapt) begin
        drift_bias <= drift_next;
      end
      if (ctl.accept && ctl.calib) begin
        calib_sum <= ctl.calib_end ? '0 : sum_next;
      end
      if (div_done) begin
        static_bias <= div_q;
      end else if (ctl.accept && ctl.calib_first) begin
        static_bias <= '0;
      end
      if (ctl.filt_update) begin
        smoothed_rate <= smooth_calc;
      end
    end
  end

  // Stage 1 rate
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      rate_s1 <= rate;
    end
  end

endmodule
`default_nettype wire

// ===== tb/sv/gyro_bias_compensation_filter_unit_test.sv =====
// Self-checking stream testbench for the gyro bias compensation filter unit.
module gyro_bias_compensation_filter_unit_test;
  import gbc_pkg::*;

  localparam longint RATE_HI = (longint'(1) <<< (RATE_W - 1)) - 1;
  localparam longint RATE_LO = -RATE_HI - 1;
  localparam int FIELD_COUNT = 2 * AXES;
  localparam int PHASES = 8;

  typedef struct packed {
    logic comp;
    logic [FIELD_COUNT*RATE_W-1:0] fields;  // rates then smoothed rates, axis 0 lowest
  } rate_word_t;

  // Bit-true model of the corrector plus the store of expected output words
  class gyro_rate_scoreboard;
    longint static_bias[AXES];
    longint drift_bias[AXES];
    longint smooth_rate[AXES];
    longint calib_sum[AXES];
    int calib_count;
    int still_count;
    bit comp_on;
    longint threshold, settle, gain, lpf;
    rate_word_t expected_words[$];
    int errors, samples, checked, calibrations, drift_moves;
    string field_names[FIELD_COUNT] =
      '{"rate_a", "rate_b", "rate_c", "smooth_a", "smooth_b", "smooth_c"};

    function new();
      threshold = THRESHOLD_RST;
      settle = SETTLE_RST;
      gain = GAIN_RST;
      lpf = LPF_RST;
    endfunction

    function void set_register(reg_idx_t idx, logic [31:0] val);
      case (idx)
        REG_THRESHOLD: threshold = val[THR_W-1:0];
        REG_SETTLE: settle = val[SETTLE_W-1:0];
        REG_GAIN: gain = val[GAIN_W-1:0];
        default: lpf = val[GAIN_W-1:0];
      endcase
    endfunction

    function longint clamp_rate(longint v);
      if (v > RATE_HI) return RATE_HI;
      if (v < RATE_LO) return RATE_LO;
      return v;
    endfunction

    function void note_sample(bit calib, logic [47:0] bytes);
      longint raw[AXES];
      longint rate[AXES];
      longint acc;
      longint mag;
      bit still;
      rate_word_t w;
      samples++;
      // axis 0 = raw y, axis 1 = raw x, axis 2 = -raw z
      raw[0] = longint'($signed(bytes[31:16]));
      raw[1] = longint'($signed(bytes[15:0]));
      raw[2] = -longint'($signed(bytes[47:32]));
      if (calib && calib_count == 0) begin
        for (int i = 0; i < AXES; i++) begin
          static_bias[i] = 0;
          calib_sum[i] = 0;
        end
      end
      for (int i = 0; i < AXES; i++) begin
        rate[i] = clamp_rate(raw[i] * (longint'(1) <<< FRAC_BITS_DEF) - static_bias[i]);
        if (comp_on) rate[i] = clamp_rate(rate[i] - drift_bias[i]);
      end
      // stationary test and drift tracking
      if (comp_on) begin
        still = 1'b1;
        for (int i = 0; i < AXES; i++) begin
          mag = (rate[i] < 0) ? -rate[i] : rate[i];
          if (mag >= threshold) still = 1'b0;
        end
        if (still) begin
          if (still_count < 65535) still_count++;
          if (still_count > settle) begin
            drift_moves++;
            for (int i = 0; i < AXES; i++)
              drift_bias[i] = clamp_rate(drift_bias[i] + ((rate[i] * gain) >>> 16));
          end
        end else begin
          still_count = 0;
        end
      end
      // calibration average or low-pass update
      if (calib) begin
        for (int i = 0; i < AXES; i++) calib_sum[i] += rate[i];
        calib_count++;
        if (calib_count >= CALIB_SAMPLES_DEF) begin
          for (int i = 0; i < AXES; i++) begin
            static_bias[i] = clamp_rate(calib_sum[i] / CALIB_SAMPLES_DEF);
            calib_sum[i] = 0;
          end
          calib_count = 0;
          comp_on = 1'b1;
          calibrations++;
        end
      end else begin
        for (int i = 0; i < AXES; i++) begin
          acc = rate[i] * lpf + smooth_rate[i] * (65536 - lpf) + 32768;
          smooth_rate[i] = clamp_rate(acc >>> 16);
        end
      end
      w.comp = comp_on;
      for (int i = 0; i < AXES; i++) begin
        w.fields[RATE_W*i +: RATE_W] = rate[i][RATE_W-1:0];
        w.fields[RATE_W*(i+AXES) +: RATE_W] = smooth_rate[i][RATE_W-1:0];
      end
      expected_words.push_back(w);
    endfunction

    function void check_output(logic [151:0] tdata, logic comp);
      rate_word_t w;
      if (expected_words.size() == 0) begin
        errors++;
        $error("result word with no sample pending");
        return;
      end
      w = expected_words.pop_front();
      checked++;
      for (int i = 0; i < FIELD_COUNT; i++) begin
        if (tdata[RATE_W*i +: RATE_W] !== w.fields[RATE_W*i +: RATE_W]) begin
          errors++;
          $error("%s: expected %0d, got %0d", field_names[i],
                 $signed(w.fields[RATE_W*i +: RATE_W]), $signed(tdata[RATE_W*i +: RATE_W]));
        end
      end
      if (comp !== w.comp) begin
        errors++;
        $error("compensating: expected %0d, got %0d", w.comp, comp);
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic [47:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [151:0] m_tdata;
  logic [0:0] m_tuser;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  int sender_idle = 0;
  int recv_stall = 0;
  gyro_rate_scoreboard sb;

  gyro_bias_compensation_filter_unit uut (
    .clk(clk),
    .rst(rst),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("[gyro_bias_compensation_filter_unit] ERROR");
    $finish;
  end

  // Monitor both handshakes; receiver stalls at random
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_sample(s_tuser[0], s_tdata);
      if (m_tvalid && m_tready) sb.check_output(m_tdata, m_tuser[0]);
    end
    m_tready <= ($urandom_range(99) >= recv_stall);
  end

  function automatic logic [15:0] to_axis(int v);
    int c;
    c = (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
    return c[15:0];
  endfunction

  // {z, y, x}, each little-endian byte pair
  function automatic logic [47:0] pack_axes(int x, int y, int z);
    return {to_axis(z), to_axis(y), to_axis(x)};
  endfunction

  function automatic int jitter(int base, int spread);
    return base + int'($urandom_range(2 * spread)) - spread;
  endfunction

  function automatic int pick_extreme();
    case ($urandom_range(3))
      0: return -32768;
      1: return 32767;
      2: return 0;
      default: return -1;
    endcase
  endfunction

  task automatic send_sample(bit calib, logic [47:0] bytes);
    while ($urandom_range(99) < sender_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= bytes;
    s_tuser <= calib;
    do @(posedge clk); while (!s_tready);
  endtask

  // Hold the sender until every expected word is back, then let the block settle
  task automatic await_results();
    s_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_register(reg_idx_t idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_register(idx, val);
    @(posedge clk);
  endtask

  // Mostly still samples around the phase offset, plus noise and extremes
  task automatic send_mixed(int bx, int by, int bz, int spread);
    int r;
    logic [63:0] noise_bits;
    r = $urandom_range(99);
    noise_bits = {$urandom(), $urandom()};
    if (r < 70)
      send_sample(1'b0, pack_axes(jitter(bx, spread), jitter(by, spread), jitter(bz, spread)));
    else if (r < 82)
      send_sample(1'($urandom_range(1)), noise_bits[47:0]);
    else if (r < 94)
      send_sample(1'b0, pack_axes(pick_extreme(), pick_extreme(), pick_extreme()));
    else
      send_sample(1'b1, pack_axes(jitter(bx, spread), jitter(by, spread), jitter(bz, spread)));
  endtask

  initial begin
    int bx, by, bz, spread, mode, tail;
    logic [31:0] thr, settle, gain, lpf;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, byte patterns, calibration start with interleaving
    send_sample(1'b0, pack_axes(0, 0, 0));
    send_sample(1'b0, pack_axes(32767, -32768, -32768));
    send_sample(1'b0, pack_axes(-32768, 32767, 32767));
    send_sample(1'b0, pack_axes(-1, -1, -1));
    send_sample(1'b0, 48'h00FF_00FF_00FF);
    send_sample(1'b0, 48'hFF00_FF00_FF00);
    send_sample(1'b1, pack_axes(0, 0, 0));
    send_sample(1'b0, pack_axes(100, -100, 50));
    send_sample(1'b1, pack_axes(32767, -32768, -32768));
    send_sample(1'b1, pack_axes(-32768, 32767, 32767));
    send_sample(1'b0, pack_axes(-32768, -32768, 32767));
    send_sample(1'b1, pack_axes(1, 2, 3));
    send_sample(1'b0, 48'hFFFF_FFFF_FFFF);

    for (int p = 0; p < PHASES; p++) begin
      await_results();
      case (p)
        0: begin
          thr = 16000; settle = 3; gain = 30000; lpf = 20000;
        end
        1: begin
          thr = 0; settle = 0; gain = 65535; lpf = 0;
        end
        2: begin
          thr = 8388607; settle = 0; gain = 65535; lpf = 65535;
        end
        3: begin
          thr = $urandom_range(40000, 2000); settle = 65535; gain = 0;
          lpf = $urandom_range(65535);
        end
        default: begin
          thr = $urandom_range(60000, 1000); settle = $urandom_range(20);
          gain = $urandom_range(65535); lpf = $urandom_range(65535);
        end
      endcase
      write_register(REG_THRESHOLD, thr);
      write_register(REG_SETTLE, settle);
      write_register(REG_GAIN, gain);
      write_register(REG_LPF, lpf);

      // idle pattern: none, sender, receiver, both light
      mode = (p + p / 4) % 4;
      sender_idle = (mode == 1) ? 52 : (mode == 3) ? 6 : 0;
      recv_stall = (mode == 2) ? 52 : (mode == 3) ? 6 : 0;

      if (p == 2) begin
        bx = 32767; by = -32768; bz = 32767;
      end else begin
        bx = jitter(0, 2000); by = jitter(0, 2000); bz = jitter(0, 2000);
      end
      spread = $urandom_range(40, 1);

      // On even phases, a full calibration run with a few mixed words interleaved
      if (p % 2 == 0) begin
        for (int k = 0; k < CALIB_SAMPLES_DEF; k++) begin
          if ($urandom_range(99) < 8) send_mixed(bx, by, bz, spread);
          send_sample(1'b1, pack_axes(jitter(bx, spread), jitter(by, spread),
                                      jitter(bz, spread)));
        end
      end

      tail = (p % 2 == 0) ? 35 : 140;
      for (int k = 0; k < tail; k++) begin
        if (p == 3 && k == 70) await_results();
        send_mixed(bx, by, bz, spread);
      end
    end

    await_results();
    $display("Ran %0d sample words, %0d result words checked, over %0d register settings.",
             sb.samples, sb.checked, PHASES);
    $display("Calibrations closed: %0d; drift bias updates: %0d.",
             sb.calibrations, sb.drift_moves);
    if (sb.errors == 0) begin
      $display("[gyro_bias_compensation_filter_unit] OK");
    end else begin
      $display("[gyro_bias_compensation_filter_unit] ERROR");
    end
    $finish;
  end

endmodule
